>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the deframer RTL
// Clocked assertions sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

>>> rtl/core/dsd_pkg.sv
// ----------------------------------------------------------------------------
// dsd_pkg
// Types and codes shared by the escape-stuffed packet deframer modules.
// ----------------------------------------------------------------------------
package dsd_pkg;

  // Parser phase; code 7 is unused and treated as hunting
  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_ID    = 3'd1,
    PH_SIZE  = 3'd2,
    PH_DATA  = 3'd3,
    PH_CSUM  = 3'd4,
    PH_TRAIL = 3'd5,
    PH_END   = 3'd6
  } phase_t;

  // Result kind
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_HEADER = 3'd1,
    ERR_OVERSIZE  = 3'd2,
    ERR_NO_TRAIL  = 3'd3,
    ERR_NO_END    = 3'd4
  } err_t;

  // Configuration register indexes
  localparam logic [1:0] REG_ESCAPE  = 2'd0;
  localparam logic [1:0] REG_END     = 2'd1;
  localparam logic [1:0] REG_MAX_LEN = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0] ESCAPE_RST  = 8'd16;
  localparam logic [7:0] END_RST     = 8'd3;
  localparam logic [7:0] MAX_LEN_RST = 8'd255;

  // Result command passed from the parser to the output side
  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic [7:0] packet_id;
    logic [7:0] payload_length;
    logic [7:0] byte_index;
    err_t       error_code;
  } dsd_cmd_t;

endpackage

>>> rtl/core/dsd_front.sv
// ----------------------------------------------------------------------------
// dsd_front
// Byte parser: holds the configuration registers, unstuffs escaped bytes,
// tracks the frame phase and pushes one result command per emitting byte.
// ----------------------------------------------------------------------------
module dsd_front (
  input  logic              clk,
  input  logic              rst_n,
  // byte input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  // configuration writes
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  // queue side
  input  logic              q_full,
  output logic              q_push,
  output dsd_pkg::dsd_cmd_t q_cmd
);
  import dsd_pkg::*;

  logic [7:0] escape_r, end_r, max_len_r;
  phase_t     phase_r, phase_nxt;
  logic       esc_pend_r, esc_pend_nxt;
  logic [7:0] id_r, id_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] csum_r, csum_nxt;
  logic       accept;
  logic       stuffed;
  logic [7:0] cnt_inc;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign stuffed  = (phase_r == PH_SIZE) || (phase_r == PH_DATA) || (phase_r == PH_CSUM);
  assign cnt_inc  = cnt_r + 8'd1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r  <= ESCAPE_RST;
      end_r     <= END_RST;
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ESCAPE:  escape_r  <= cfg_wdata;
        REG_END:     end_r     <= cfg_wdata;
        REG_MAX_LEN: max_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      esc_pend_r <= 1'b0;
      id_r       <= '0;
      len_r      <= '0;
      cnt_r      <= '0;
      csum_r     <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      esc_pend_r <= esc_pend_nxt;
      id_r       <= id_nxt;
      len_r      <= len_nxt;
      cnt_r      <= cnt_nxt;
      csum_r     <= csum_nxt;
    end
  end

  // Next state and result command
  always_comb begin
    phase_nxt    = phase_r;
    esc_pend_nxt = esc_pend_r;
    id_nxt       = id_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    csum_nxt     = csum_r;
    q_push       = 1'b0;
    q_cmd.kind           = KIND_ERR;
    q_cmd.value          = '0;
    q_cmd.packet_id      = id_r;
    q_cmd.payload_length = len_r;
    q_cmd.byte_index     = '0;
    q_cmd.error_code     = ERR_NONE;

    if (stuffed && !esc_pend_r && (in_rx_byte == escape_r)) begin
      // escape inside a stuffed field: drop it, take the next byte as is
      esc_pend_nxt = 1'b1;
    end else begin
      if (stuffed) esc_pend_nxt = 1'b0;
      unique case (phase_r)
        PH_ID: begin
          id_nxt    = in_rx_byte;
          phase_nxt = PH_SIZE;
        end
        PH_SIZE: begin
          len_nxt = in_rx_byte;
          cnt_nxt = '0;
          if (in_rx_byte > max_len_r) begin
            q_push               = accept;
            q_cmd.payload_length = in_rx_byte;
            q_cmd.error_code     = ERR_OVERSIZE;
            phase_nxt            = PH_HUNT;
            esc_pend_nxt         = 1'b0;
          end else begin
            phase_nxt = (in_rx_byte == 8'd0) ? PH_CSUM : PH_DATA;
          end
        end
        PH_DATA: begin
          q_push           = accept;
          q_cmd.kind       = KIND_DATA;
          q_cmd.value      = in_rx_byte;
          q_cmd.byte_index = cnt_r;
          cnt_nxt          = cnt_inc;
          if (cnt_inc >= len_r) phase_nxt = PH_CSUM;
        end
        PH_CSUM: begin
          csum_nxt  = in_rx_byte;
          phase_nxt = PH_TRAIL;
        end
        PH_TRAIL: begin
          if (in_rx_byte != escape_r) begin
            q_push           = accept;
            q_cmd.error_code = ERR_NO_TRAIL;
            phase_nxt        = PH_HUNT;
            esc_pend_nxt     = 1'b0;
          end else begin
            phase_nxt = PH_END;
          end
        end
        PH_END: begin
          q_push       = accept;
          phase_nxt    = PH_HUNT;
          esc_pend_nxt = 1'b0;
          if (in_rx_byte != end_r) begin
            q_cmd.error_code = ERR_NO_END;
          end else begin
            q_cmd.kind  = KIND_DONE;
            q_cmd.value = csum_r;
          end
        end
        default: begin
          // hunting for the header escape (also the unused phase code)
          esc_pend_nxt = 1'b0;
          if (in_rx_byte == escape_r) begin
            phase_nxt = PH_ID;
          end else begin
            q_push               = accept;
            q_cmd.packet_id      = '0;
            q_cmd.payload_length = '0;
            q_cmd.error_code     = ERR_NO_HEADER;
            phase_nxt            = PH_HUNT;
          end
        end
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_esc_only_stuffed, esc_pend_r |-> stuffed, "escape pending outside a stuffed field")
  `ASSERT_CLK(a_cnt_below_len, (phase_r == PH_DATA) |-> (cnt_r < len_r), "data count reached length in data phase")

endmodule

>>> rtl/core/dsd_queue.sv
// ----------------------------------------------------------------------------
// dsd_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module dsd_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dsd_pkg::dsd_cmd_t push_cmd,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output dsd_pkg::dsd_cmd_t head_cmd
);
  import dsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dsd_cmd_t           slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = slot_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

`include "assert_macros.svh"

  `ASSERT_NEVER(a_no_overflow, push && full && !pop, "push into a full queue")
  `ASSERT_NEVER(a_no_underflow, pop && !not_empty, "pop from an empty queue")
  `ASSERT_CLK(a_empty_ptrs, (count_r == '0) |-> (wr_ptr_r == rd_ptr_r), "pointers differ while empty")

endmodule

>>> rtl/core/dsd_back.sv
// ----------------------------------------------------------------------------
// dsd_back
// Output stage: takes result commands from the queue, marks the closing
// results and holds each result until the receiver takes it.
// ----------------------------------------------------------------------------
module dsd_back (
  input  logic              clk,
  input  logic              rst_n,
  // queue side
  input  logic              q_not_empty,
  input  dsd_pkg::dsd_cmd_t q_head,
  output logic              q_pop,
  // result output
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_value,
  output logic [7:0]        out_packet_id,
  output logic [7:0]        out_payload_length,
  output logic [7:0]        out_byte_index,
  output logic [2:0]        out_error_code,
  output logic              out_last
);
  import dsd_pkg::*;

  logic     valid_r;
  dsd_cmd_t res_r;
  logic     last_r;
  logic     load;

  // Load when the output register is free or being drained
  assign load  = q_not_empty && (!valid_r || !out_stall);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // Result payload; frame-complete and error results close the frame
  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= q_head;
      last_r <= (q_head.kind != KIND_DATA);
    end
  end

  assign out_valid          = valid_r;
  assign out_kind           = res_r.kind;
  assign out_value          = res_r.value;
  assign out_packet_id      = res_r.packet_id;
  assign out_payload_length = res_r.payload_length;
  assign out_byte_index     = res_r.byte_index;
  assign out_error_code     = res_r.error_code;
  assign out_last           = last_r;

endmodule

>>> rtl/core/dle_stuffed_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// dle_stuffed_packet_deframer_top
// Escape-stuffed packet deframer: parser, result queue and output stage.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle when in_stall is low; the parser
// updates its frame state as each byte is taken, so the sustained rate is one
// byte a cycle while in_stall stays low. A byte that produces a result reaches
// the output through the queue slot, written when the byte is taken, and then
// the output register.
// in_stall rises only when the QUEUE_DEPTH-entry result queue is full, which
// with QUEUE_DEPTH above one comes only from out_stall. Configuration writes take
// effect from the next byte and should be made between frames.
module dle_stuffed_packet_deframer_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  // byte input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // result output
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_value,
  output logic [7:0] out_packet_id,
  output logic [7:0] out_payload_length,
  output logic [7:0] out_byte_index,
  output logic [2:0] out_error_code,
  output logic       out_last,
  // configuration
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import dsd_pkg::*;

  logic     q_full, q_push, q_pop, q_not_empty;
  dsd_cmd_t q_cmd, q_head;

  // Parser
  dsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  // Result queue
  dsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_cmd  (q_head)
  );

  // Output stage
  dsd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_not_empty        (q_not_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_value          (out_value),
    .out_packet_id      (out_packet_id),
    .out_payload_length (out_payload_length),
    .out_byte_index     (out_byte_index),
    .out_error_code     (out_error_code),
    .out_last           (out_last)
  );

endmodule

>>> tb/dle_stuffed_packet_deframer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dle_stuffed_packet_deframer_top_tb
// Drives raw link bytes into the deframer and checks every result transfer
// against an in-bench model of the frame parser. Covers stuffing, empty and
// long payloads, every framing fault, register extremes and random traffic,
// with random input gaps and random result stalls.
// ----------------------------------------------------------------------------
module dle_stuffed_packet_deframer_top_tb;
  import dsd_pkg::*;

  // Index past the end of the register map; writes to it are dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_TRAIL,
    FRAME_BAD_END,
    FRAME_OVERSIZE
  } frame_fault_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic [7:0] packet_id;
    logic [7:0] payload_length;
    logic [7:0] byte_index;
    err_t       error_code;
    logic       last;
  } deframed_result_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_value;
  logic [7:0] out_packet_id;
  logic [7:0] out_payload_length;
  logic [7:0] out_byte_index;
  logic [2:0] out_error_code;
  logic       out_last;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  // Register copies and parser state of the model
  logic [7:0] reg_escape;
  logic [7:0] reg_end;
  logic [7:0] reg_max_len;
  phase_t     parse_phase;
  logic       escape_seen;
  logic [7:0] held_id;
  logic [7:0] held_length;
  logic [7:0] data_count;
  logic [7:0] held_checksum;

  deframed_result_t pending_results[$];
  int  sent_bytes  = 0;
  int  fail_count  = 0;
  bit  idle_enabled = 1'b1;
  int  stall_left  = 0;

  dle_stuffed_packet_deframer_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_value          (out_value),
    .out_packet_id      (out_packet_id),
    .out_payload_length (out_payload_length),
    .out_byte_index     (out_byte_index),
    .out_error_code     (out_error_code),
    .out_last           (out_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic void post_result(kind_t k, logic [7:0] v, logic [7:0] pid,
                                      logic [7:0] plen, logic [7:0] idx,
                                      err_t code, logic fin);
    deframed_result_t r;
    r.kind           = k;
    r.value          = v;
    r.packet_id      = pid;
    r.payload_length = plen;
    r.byte_index     = idx;
    r.error_code     = code;
    r.last           = fin;
    pending_results.push_back(r);
  endfunction

  // Framing fault inside a frame: report held id/length, back to hunting
  function automatic void reject_frame(err_t code);
    post_result(KIND_ERR, 8'h00, held_id, held_length, 8'h00, code, 1'b1);
    parse_phase = PH_HUNT;
    escape_seen = 1'b0;
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    // unstuffing applies to size, data and checksum only
    if (parse_phase == PH_SIZE || parse_phase == PH_DATA || parse_phase == PH_CSUM) begin
      if (!escape_seen && b == reg_escape) begin
        escape_seen = 1'b1;
        return;
      end
      escape_seen = 1'b0;
    end
    case (parse_phase)
      PH_ID: begin
        held_id     = b;
        parse_phase = PH_SIZE;
      end
      PH_SIZE: begin
        held_length = b;
        data_count  = 8'h00;
        if (b > reg_max_len) reject_frame(ERR_OVERSIZE);
        else if (b == 8'h00) parse_phase = PH_CSUM;
        else parse_phase = PH_DATA;
      end
      PH_DATA: begin
        post_result(KIND_DATA, b, held_id, held_length, data_count, ERR_NONE, 1'b0);
        data_count = data_count + 8'd1;
        if (data_count >= held_length) parse_phase = PH_CSUM;
      end
      PH_CSUM: begin
        held_checksum = b;
        parse_phase   = PH_TRAIL;
      end
      PH_TRAIL: begin
        if (b != reg_escape) reject_frame(ERR_NO_TRAIL);
        else parse_phase = PH_END;
      end
      PH_END: begin
        if (b != reg_end) begin
          reject_frame(ERR_NO_END);
        end else begin
          post_result(KIND_DONE, held_checksum, held_id, held_length, 8'h00, ERR_NONE, 1'b1);
          parse_phase = PH_HUNT;
        end
      end
      default: begin
        // hunting (and the spare phase code)
        escape_seen = 1'b0;
        if (b == reg_escape) begin
          parse_phase = PH_ID;
        end else begin
          parse_phase = PH_HUNT;
          post_result(KIND_ERR, 8'h00, 8'h00, 8'h00, 8'h00, ERR_NO_HEADER, 1'b1);
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, checked at the rising edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n || !idle_enabled) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    deframed_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: kind %0d value %0d", out_kind, out_value);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("value", want.value, out_value);
        check_field("packet_id", want.packet_id, out_packet_id);
        check_field("payload_length", want.payload_length, out_payload_length);
        check_field("byte_index", want.byte_index, out_byte_index);
        check_field("error_code", want.error_code, out_error_code);
        check_field("last", want.last, out_last);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Byte side
  // --------------------------------------------------------------------------
  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] b);
    if (idle_enabled && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    deframe_byte(b);
    sent_bytes++;
    @(negedge clk);
  endtask

  // Stuffed field byte; sometimes escapes a byte that needs no escaping
  task automatic send_stuffed(input logic [7:0] b);
    if (b == reg_escape || $urandom_range(0, 15) == 0) send_byte(reg_escape);
    send_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                            input frame_fault_t fault);
    logic [7:0] b;
    send_byte(reg_escape);
    send_byte(id);
    send_stuffed(len);
    if (fault == FRAME_OVERSIZE) return;
    repeat (len) send_stuffed(8'($urandom));
    send_stuffed(8'($urandom));
    b = reg_escape;
    if (fault == FRAME_BAD_TRAIL) begin
      while (b == reg_escape) b = 8'($urandom);
      send_byte(b);
      return;
    end
    send_byte(b);
    b = reg_end;
    if (fault == FRAME_BAD_END) begin
      while (b == reg_end) b = 8'($urandom);
    end
    send_byte(b);
  endtask

  task automatic send_random_frame();
    int            pick;
    frame_fault_t  fault;
    logic [7:0]    len;
    logic [7:0]    cap;
    pick = $urandom_range(0, 99);
    cap  = (reg_max_len < 8'd8) ? reg_max_len : 8'd8;
    // mostly short payloads, now and then anything up to the limit
    if ($urandom_range(0, 39) == 0) len = 8'($urandom_range(0, reg_max_len));
    else len = 8'($urandom_range(0, cap));
    if (pick < 8) begin
      // line noise
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      return;
    end
    fault = FRAME_GOOD;
    if (pick < 16) begin
      fault = FRAME_BAD_TRAIL;
    end else if (pick < 24) begin
      fault = FRAME_BAD_END;
    end else if (pick < 32 && reg_max_len != 8'hFF) begin
      fault = FRAME_OVERSIZE;
      len   = 8'($urandom_range(reg_max_len + 1, 255));
    end
    send_frame(8'($urandom), len, fault);
  endtask

  task automatic run_frames(input int n_bytes);
    int start;
    start = sent_bytes;
    while (sent_bytes - start < n_bytes) send_random_frame();
  endtask

  // Hold the byte side until every predicted result has been seen
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  // Leaves cfg_we high; the caller lowers it after the last write
  task automatic write_register(input logic [1:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    case (idx)
      REG_ESCAPE:  reg_escape  = data;
      REG_END:     reg_end     = data;
      REG_MAX_LEN: reg_max_len = data;
      default: ;
    endcase
  endtask

  task automatic program_registers(input logic [7:0] esc, input logic [7:0] endb,
                                   input logic [7:0] maxp);
    drain_results();
    // bytes with no result may still be in the parser
    repeat (4) @(negedge clk);
    write_register(REG_ESCAPE, esc);
    write_register(REG_END, endb);
    write_register(REG_MAX_LEN, maxp);
    write_register(REG_UNUSED, 8'($urandom));
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset register values: missing header, empty payload, stuffing, faults
  task automatic test_directed_frames();
    // bytes outside a frame
    send_byte(8'h00);
    send_byte(8'hFF);
    // empty payload, escaped size, checksum equal to the escape
    send_byte(reg_escape);
    send_byte(8'hFF);
    send_byte(reg_escape);
    send_byte(8'h00);
    send_byte(reg_escape);
    send_byte(reg_escape);
    send_byte(reg_escape);
    send_byte(reg_end);
    // two stuffed data bytes, then no trailer escape
    send_byte(reg_escape);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(reg_escape);
    send_byte(reg_escape);
    send_byte(reg_escape);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    // trailer present, end byte missing
    send_byte(reg_escape);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(reg_escape);
    send_byte(reg_escape);
  endtask

  // Zero length limit: any data is oversize, an empty frame still passes
  task automatic test_oversize();
    program_registers(ESCAPE_RST, END_RST, 8'h00);
    send_frame(8'h42, 8'h01, FRAME_OVERSIZE);
    send_frame(8'h7E, 8'h00, FRAME_GOOD);
  endtask

  task automatic test_register_extremes();
    program_registers(8'h00, 8'hFF, 8'h00);
    run_frames(150);
    program_registers(8'hFF, 8'h00, 8'hFF);
    run_frames(150);
  endtask

  task automatic test_random_traffic();
    logic [7:0] maxp;
    for (int p = 0; p < 6; p++) begin
      maxp = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 12));
      program_registers(8'($urandom), 8'($urandom), maxp);
      // every third phase runs without idling
      idle_enabled = (p % 3 != 2);
      run_frames(100);
      if (p == 1) drain_results();
      run_frames(100);
    end
    idle_enabled = 1'b1;
  endtask

  task automatic test_back_to_back();
    program_registers(ESCAPE_RST, END_RST, MAX_LEN_RST);
    idle_enabled = 1'b0;
    run_frames(450);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_rx_byte  = 8'h00;
    cfg_we      = 1'b0;
    cfg_index   = REG_ESCAPE;
    cfg_wdata   = 8'h00;
    reg_escape  = ESCAPE_RST;
    reg_end     = END_RST;
    reg_max_len = MAX_LEN_RST;
    parse_phase = PH_HUNT;
    escape_seen = 1'b0;
    held_id       = 8'h00;
    held_length   = 8'h00;
    data_count    = 8'h00;
    held_checksum = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_oversize();
    test_register_extremes();
    test_random_traffic();
    test_back_to_back();

    drain_results();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("dle_stuffed_packet_deframer_top_tb OK");
    end else begin
      $display("dle_stuffed_packet_deframer_top_tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("dle_stuffed_packet_deframer_top_tb NOT OK");
    $finish;
  end

endmodule
